[hw/rtl/rgb_hsv_cmyk_converter_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the color space converter
// Concurrent checks on clk with disable on rst_n; empty under SYNTH.
// ----------------------------------------------------------------------------
`ifndef RGB_HSV_CMYK_CONVERTER_MACROS_SVH
`define RGB_HSV_CMYK_CONVERTER_MACROS_SVH

`ifndef SYNTH
`define RHCC_ASSERT_HOLDS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define RHCC_ASSERT_IMPLIES(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
`else
`define RHCC_ASSERT_HOLDS(lbl, cond, msg)
`define RHCC_ASSERT_IMPLIES(lbl, pre, post, msg)
`endif

`endif

[hw/rtl/rhcc_pkg.sv]
// ----------------------------------------------------------------------------
// rhcc_pkg
// Shared types and constants of the RGB / HSV / CMYK color converter.
// ----------------------------------------------------------------------------
package rhcc_pkg;

    typedef enum logic [1:0] {
        CMD_RGB  = 2'd0,
        CMD_CMYK = 2'd1,
        CMD_HSV  = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    localparam logic [7:0]  LVL_MAX   = 8'd255;
    localparam logic [8:0]  HUE_FULL  = 9'd360;
    localparam logic [8:0]  HUE_SECT  = 9'd60;
    localparam logic [17:0] HUE_G_OFS = 18'd120;
    localparam logic [17:0] HUE_B_OFS = 18'd240;
    localparam logic [13:0] DEN_CMYK  = 14'd255;
    localparam logic [13:0] DEN_HSV   = 14'd15300;

    // Fields that travel down the pipe next to the arithmetic
    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] cyan;
        logic [7:0] magenta;
        logic [7:0] yellow;
        logic [7:0] black;
        logic [8:0] hue;
        logic [7:0] sat;
        logic [7:0] val;
    } carry_t;

    typedef struct packed {
        logic [7:0] mx;
        logic       mx_zero;
        logic       d_zero;
    } rgb_info_t;

endpackage

[hw/rtl/rhcc_req_if.sv]
// ----------------------------------------------------------------------------
// rhcc_req_if
// Input channel: one color with its source space.
// ----------------------------------------------------------------------------
interface rhcc_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] cyan;
    logic [7:0] magenta;
    logic [7:0] yellow;
    logic [7:0] key_black;
    logic [8:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;

    modport source (output valid, command, red, green, blue, cyan, magenta, yellow,
                    key_black, hue, saturation, brightness, input ready);
    modport sink   (input valid, command, red, green, blue, cyan, magenta, yellow,
                    key_black, hue, saturation, brightness, output ready);
endinterface

[hw/rtl/rhcc_rsp_if.sv]
// ----------------------------------------------------------------------------
// rhcc_rsp_if
// Output channel: the color in all three spaces.
// ----------------------------------------------------------------------------
interface rhcc_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] res_red;
    logic [7:0] res_green;
    logic [7:0] res_blue;
    logic [7:0] res_cyan;
    logic [7:0] res_magenta;
    logic [7:0] res_yellow;
    logic [7:0] res_black;
    logic [8:0] res_hue;
    logic [7:0] res_saturation;
    logic [7:0] res_brightness;

    modport source (output valid, res_red, res_green, res_blue, res_cyan, res_magenta,
                    res_yellow, res_black, res_hue, res_saturation, res_brightness,
                    input ready);
    modport sink   (input valid, res_red, res_green, res_blue, res_cyan, res_magenta,
                    res_yellow, res_black, res_hue, res_saturation, res_brightness,
                    output ready);
endinterface

[hw/rtl/rgb_hsv_cmyk_converter.sv]
// ----------------------------------------------------------------------------
// rgb_hsv_cmyk_converter
// Converts one color given in RGB, CMYK or HSV to all three spaces.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake      | payload
//  request   | in  | valid / ready  | command, RGB, CMYK, HSV source fields
//  result    | out | valid / ready  | res_* fields in RGB, CMYK and HSV
//
//  Ten register stages: operand prep, numerator build, three divider stages
//  to RGB, min/max analysis, three divider stages from RGB, output register.
//  One transaction per cycle is accepted and delivered while result.ready is high.
//  The restoring dividers (3 quotient bits per stage) set the depth.
//  Each stage has its own valid bit and takes data when it is empty or moves
//  on, so a stall at the output fills bubbles before it halts the input.
//  rst_n clears only the valid bits.
// ----------------------------------------------------------------------------
`include "rgb_hsv_cmyk_converter_macros.svh"

module rgb_hsv_cmyk_converter (
    input  logic       clk,
    input  logic       rst_n,
    rhcc_req_if.sink   request,
    rhcc_rsp_if.source result
);
    import rhcc_pkg::*;

    localparam int NSTG = 10;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] rdy;

    always_comb
    begin
        rdy[NSTG-1] = !vld_reg[NSTG-1] || result.ready;
        for (int i = NSTG - 2; i >= 0; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    always_comb
    begin
        vld_next[0] = rdy[0] ? request.valid : vld_reg[0];
        for (int i = 1; i < NSTG; i++)
        begin
            vld_next[i] = rdy[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign request.ready = rdy[0];
    assign result.valid  = vld_reg[NSTG-1];

    // ---------------- stage A: operand prep
    carry_t      a_carry_reg, a_carry_next;
    logic [15:0] a_vs_reg, a_vs_next;
    logic [5:0]  a_t_reg, a_t_next;
    logic [2:0]  a_sec_reg, a_sec_next;
    logic [15:0] a_p_reg [3];
    logic [15:0] a_p_next [3];

    always_comb
    begin
        logic [8:0] hr;
        logic [8:0] rem;
        hr = (request.hue >= HUE_FULL) ? request.hue - HUE_FULL : request.hue;
        if (hr >= 9'd300)      a_sec_next = 3'd5;
        else if (hr >= 9'd240) a_sec_next = 3'd4;
        else if (hr >= 9'd180) a_sec_next = 3'd3;
        else if (hr >= 9'd120) a_sec_next = 3'd2;
        else if (hr >= 9'd60)  a_sec_next = 3'd1;
        else                   a_sec_next = 3'd0;
        rem = hr - 9'(a_sec_next) * HUE_SECT;
        a_t_next = a_sec_next[0] ? 6'(HUE_SECT - rem) : rem[5:0];
        a_vs_next = 16'(request.saturation) * 16'(request.brightness);
        a_p_next[0] = 16'(LVL_MAX - request.cyan) * 16'(LVL_MAX - request.key_black);
        a_p_next[1] = 16'(LVL_MAX - request.magenta) * 16'(LVL_MAX - request.key_black);
        a_p_next[2] = 16'(LVL_MAX - request.yellow) * 16'(LVL_MAX - request.key_black);
        a_carry_next.cmd     = cmd_t'(request.command);
        a_carry_next.red     = request.red;
        a_carry_next.green   = request.green;
        a_carry_next.blue    = request.blue;
        a_carry_next.cyan    = request.cyan;
        a_carry_next.magenta = request.magenta;
        a_carry_next.yellow  = request.yellow;
        a_carry_next.black   = request.key_black;
        a_carry_next.hue     = hr;
        a_carry_next.sat     = request.saturation;
        a_carry_next.val     = request.brightness;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            a_carry_reg <= a_carry_next;
            a_vs_reg    <= a_vs_next;
            a_t_reg     <= a_t_next;
            a_sec_reg   <= a_sec_next;
            a_p_reg     <= a_p_next;
        end
    end

    // ---------------- stage B: numerators for the conversion to RGB
    carry_t      b_carry_reg;
    logic [21:0] b_num_reg [3];
    logic [21:0] b_num_next [3];
    logic [13:0] b_den_reg, b_den_next;

    always_comb
    begin
        logic [21:0] cn;
        logic [21:0] xn;
        logic [21:0] mn;
        logic [15:0] grey;
        cn = 22'(a_vs_reg) * 22'(HUE_SECT);
        xn = 22'(a_vs_reg) * 22'(a_t_reg);
        grey = ((16'(a_carry_reg.val) << 8) - 16'(a_carry_reg.val)) - a_vs_reg;
        mn = 22'(grey) * 22'(HUE_SECT);
        case (a_sec_reg)
            3'd0:    begin b_num_next[0] = cn; b_num_next[1] = xn; b_num_next[2] = '0; end
            3'd1:    begin b_num_next[0] = xn; b_num_next[1] = cn; b_num_next[2] = '0; end
            3'd2:    begin b_num_next[0] = '0; b_num_next[1] = cn; b_num_next[2] = xn; end
            3'd3:    begin b_num_next[0] = '0; b_num_next[1] = xn; b_num_next[2] = cn; end
            3'd4:    begin b_num_next[0] = xn; b_num_next[1] = '0; b_num_next[2] = cn; end
            default: begin b_num_next[0] = cn; b_num_next[1] = '0; b_num_next[2] = xn; end
        endcase
        b_den_next = DEN_HSV;
        for (int i = 0; i < 3; i++)
        begin
            b_num_next[i] = b_num_next[i] + mn;
        end
        if (a_carry_reg.cmd == CMD_CMYK)
        begin
            b_den_next = DEN_CMYK;
            for (int i = 0; i < 3; i++)
            begin
                b_num_next[i] = 22'(a_p_reg[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            b_carry_reg <= a_carry_reg;
            b_num_reg   <= b_num_next;
            b_den_reg   <= b_den_next;
        end
    end

    // ---------------- stages C: divide to RGB
    carry_t     c_carry_reg [3];
    logic [8:0] c_quo [3];

    for (genvar l = 0; l < 3; l++) begin : g_div_rgb
        rhcc_div #(.NW(22), .DW(14), .QW(9), .SPS(3)) u_div (
            .clk (clk),
            .en  (rdy[4:2]),
            .num (b_num_reg[l]),
            .den (b_den_reg),
            .quo (c_quo[l])
        );
    end

    always_ff @(posedge clk)
    begin
        if (rdy[2]) c_carry_reg[0] <= b_carry_reg;
        if (rdy[3]) c_carry_reg[1] <= c_carry_reg[0];
        if (rdy[4]) c_carry_reg[2] <= c_carry_reg[1];
    end

    // ---------------- stage D: min / max analysis, numerators from RGB
    carry_t      d_carry_reg, d_carry_next;
    rgb_info_t   d_info_reg, d_info_next;
    logic [16:0] d_num_reg [5];
    logic [16:0] d_num_next [5];
    logic [7:0]  d_den_reg [5];
    logic [7:0]  d_den_next [5];

    always_comb
    begin
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [7:0]  mx;
        logic [7:0]  mnv;
        logic [7:0]  dv;
        logic [17:0] hn;
        d_carry_next = c_carry_reg[2];
        if (c_carry_reg[2].cmd != CMD_RGB)
        begin
            d_carry_next.red   = c_quo[0][7:0];
            d_carry_next.green = c_quo[1][7:0];
            d_carry_next.blue  = c_quo[2][7:0];
        end
        r = d_carry_next.red;
        g = d_carry_next.green;
        b = d_carry_next.blue;
        mx = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        mnv = r;
        if (g < mnv) mnv = g;
        if (b < mnv) mnv = b;
        dv = mx - mnv;
        // red wins a tie, then green
        if (mx == r)
            hn = 18'(g) * 18'(HUE_SECT) + 18'(dv) * 18'(HUE_FULL) - 18'(b) * 18'(HUE_SECT);
        else if (mx == g)
            hn = 18'(b) * 18'(HUE_SECT) + 18'(dv) * HUE_G_OFS - 18'(r) * 18'(HUE_SECT);
        else
            hn = 18'(r) * 18'(HUE_SECT) + 18'(dv) * HUE_B_OFS - 18'(g) * 18'(HUE_SECT);
        d_num_next[0] = 17'(16'(mx - r) * 16'(LVL_MAX));
        d_num_next[1] = 17'(16'(mx - g) * 16'(LVL_MAX));
        d_num_next[2] = 17'(16'(mx - b) * 16'(LVL_MAX));
        d_num_next[3] = hn[16:0];
        d_num_next[4] = 17'(16'(dv) * 16'(LVL_MAX));
        d_den_next[0] = mx;
        d_den_next[1] = mx;
        d_den_next[2] = mx;
        d_den_next[3] = dv;
        d_den_next[4] = mx;
        d_info_next.mx      = mx;
        d_info_next.mx_zero = (mx == 8'd0);
        d_info_next.d_zero  = (dv == 8'd0);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[5])
        begin
            d_carry_reg <= d_carry_next;
            d_info_reg  <= d_info_next;
            d_num_reg   <= d_num_next;
            d_den_reg   <= d_den_next;
        end
    end

    // ---------------- stages E: divide from RGB
    carry_t     e_carry_reg [3];
    rgb_info_t  e_info_reg [3];
    logic [8:0] e_quo [5];

    for (genvar l = 0; l < 5; l++) begin : g_div_hsv
        rhcc_div #(.NW(17), .DW(8), .QW(9), .SPS(3)) u_div (
            .clk (clk),
            .en  (rdy[8:6]),
            .num (d_num_reg[l]),
            .den (d_den_reg[l]),
            .quo (e_quo[l])
        );
    end

    always_ff @(posedge clk)
    begin
        if (rdy[6])
        begin
            e_carry_reg[0] <= d_carry_reg;
            e_info_reg[0]  <= d_info_reg;
        end
        if (rdy[7])
        begin
            e_carry_reg[1] <= e_carry_reg[0];
            e_info_reg[1]  <= e_info_reg[0];
        end
        if (rdy[8])
        begin
            e_carry_reg[2] <= e_carry_reg[1];
            e_info_reg[2]  <= e_info_reg[1];
        end
    end

    // ---------------- output stage
    cmd_t       o_cmd_reg;
    logic [7:0] res_red_reg, res_green_reg, res_blue_reg;
    logic [7:0] res_cyan_reg, res_magenta_reg, res_yellow_reg, res_black_reg;
    logic [8:0] res_hue_reg;
    logic [7:0] res_saturation_reg, res_brightness_reg;

    logic [7:0] res_red_next, res_green_next, res_blue_next;
    logic [7:0] res_cyan_next, res_magenta_next, res_yellow_next, res_black_next;
    logic [8:0] res_hue_next;
    logic [7:0] res_saturation_next, res_brightness_next;

    always_comb
    begin
        carry_t     cr;
        rgb_info_t  inf;
        logic [7:0] cc;
        logic [7:0] cm;
        logic [7:0] cy;
        logic [8:0] hc;
        logic [7:0] sc;
        cr  = e_carry_reg[2];
        inf = e_info_reg[2];
        // black drops C, M, Y and S to zero
        cc = inf.mx_zero ? 8'd0 : e_quo[0][7:0];
        cm = inf.mx_zero ? 8'd0 : e_quo[1][7:0];
        cy = inf.mx_zero ? 8'd0 : e_quo[2][7:0];
        sc = inf.mx_zero ? 8'd0 : e_quo[4][7:0];
        if (inf.d_zero)
            hc = '0;
        else if (e_quo[3] >= HUE_FULL)
            hc = e_quo[3] - HUE_FULL;
        else
            hc = e_quo[3];
        res_red_next        = cr.red;
        res_green_next      = cr.green;
        res_blue_next       = cr.blue;
        res_cyan_next       = cc;
        res_magenta_next    = cm;
        res_yellow_next     = cy;
        res_black_next      = LVL_MAX - inf.mx;
        res_hue_next        = hc;
        res_saturation_next = sc;
        res_brightness_next = inf.mx;
        case (cr.cmd)
            CMD_RGB:
            begin
            end
            CMD_CMYK:
            begin
                res_cyan_next    = cr.cyan;
                res_magenta_next = cr.magenta;
                res_yellow_next  = cr.yellow;
                res_black_next   = cr.black;
            end
            CMD_HSV:
            begin
                res_hue_next        = cr.hue;
                res_saturation_next = cr.sat;
                res_brightness_next = cr.val;
            end
            default:
            begin
                res_red_next        = '0;
                res_green_next      = '0;
                res_blue_next       = '0;
                res_cyan_next       = '0;
                res_magenta_next    = '0;
                res_yellow_next     = '0;
                res_black_next      = '0;
                res_hue_next        = '0;
                res_saturation_next = '0;
                res_brightness_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rdy[9])
        begin
            o_cmd_reg          <= e_carry_reg[2].cmd;
            res_red_reg        <= res_red_next;
            res_green_reg      <= res_green_next;
            res_blue_reg       <= res_blue_next;
            res_cyan_reg       <= res_cyan_next;
            res_magenta_reg    <= res_magenta_next;
            res_yellow_reg     <= res_yellow_next;
            res_black_reg      <= res_black_next;
            res_hue_reg        <= res_hue_next;
            res_saturation_reg <= res_saturation_next;
            res_brightness_reg <= res_brightness_next;
        end
    end

    assign result.res_red        = res_red_reg;
    assign result.res_green      = res_green_reg;
    assign result.res_blue       = res_blue_reg;
    assign result.res_cyan       = res_cyan_reg;
    assign result.res_magenta    = res_magenta_reg;
    assign result.res_yellow     = res_yellow_reg;
    assign result.res_black      = res_black_reg;
    assign result.res_hue        = res_hue_reg;
    assign result.res_saturation = res_saturation_reg;
    assign result.res_brightness = res_brightness_reg;

    // ---------------- checks
    `RHCC_ASSERT_IMPLIES(a_hue_range, result.valid, (result.res_hue < HUE_FULL), "hue out of range")
    `RHCC_ASSERT_IMPLIES(a_drain_free, result.ready, request.ready, "ready chain blocked")
    `RHCC_ASSERT_IMPLIES(a_value_max, result.valid && (o_cmd_reg == CMD_RGB || o_cmd_reg == CMD_CMYK), (result.res_brightness >= result.res_red) && (result.res_brightness >= result.res_green) && (result.res_brightness >= result.res_blue), "value below an RGB component")

endmodule

[hw/rtl/rhcc_div.sv]
// ----------------------------------------------------------------------------
// rhcc_div
// Pipelined restoring divider, rounded to nearest with halves up:
// quo = (2*num + den) / (2*den). SPS quotient bits per register stage.
// ----------------------------------------------------------------------------
module rhcc_div #(
    parameter int NW  = 22,
    parameter int DW  = 14,
    parameter int QW  = 9,
    parameter int SPS = 3
) (
    input  logic                         clk,
    input  logic [(QW+SPS-1)/SPS-1:0]    en,
    input  logic [NW-1:0]                num,
    input  logic [DW-1:0]                den,
    output logic [QW-1:0]                quo
);
    localparam int NS = (QW + SPS - 1) / SPS;
    localparam int AW = ((NW + 1 > DW) ? NW + 1 : DW) + 1;
    localparam int W  = (AW > DW + 1 + QW) ? AW : DW + 1 + QW;

    logic [W-1:0]  rem_reg [NS];
    logic [DW:0]   dd_reg  [NS];
    logic [QW-1:0] q_reg   [NS];

    logic [W-1:0]  rem_start;
    logic [DW:0]   dd_start;

    assign rem_start = (W'(num) << 1) + W'(den);
    assign dd_start  = {den, 1'b0};

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic [W-1:0]  rem_next;
        logic [DW:0]   dd_next;
        logic [QW-1:0] q_next;

        always_comb
        begin
            logic [W-1:0] rem_w;
            logic [W-1:0] trial;
            logic [QW-1:0] q_w;
            if (s == 0)
            begin
                rem_w = rem_start;
                dd_next = dd_start;
                q_w = '0;
            end
            else
            begin
                rem_w = rem_reg[(s == 0) ? 0 : s - 1];
                dd_next = dd_reg[(s == 0) ? 0 : s - 1];
                q_w = q_reg[(s == 0) ? 0 : s - 1];
            end
            // one quotient bit per step, most significant first
            for (int j = 0; j < SPS; j++)
            begin
                if (QW - 1 - s * SPS - j >= 0)
                begin
                    trial = W'(dd_next) << (QW - 1 - s * SPS - j);
                    if (rem_w >= trial)
                    begin
                        rem_w = rem_w - trial;
                        q_w[QW - 1 - s * SPS - j] = 1'b1;
                    end
                end
            end
            rem_next = rem_w;
            q_next = q_w;
        end

        always_ff @(posedge clk)
        begin
            if (en[s])
            begin
                rem_reg[s] <= rem_next;
                dd_reg[s]  <= dd_next;
                q_reg[s]   <= q_next;
            end
        end
    end

    assign quo = q_reg[NS-1];

endmodule

[tb/rgb_hsv_cmyk_converter_tb.sv]
// ----------------------------------------------------------------------------
// rgb_hsv_cmyk_converter_tb
// Drives colors in every source space through the converter under random
// idling on both channels and compares each result with a local predictor.
// ----------------------------------------------------------------------------
module rgb_hsv_cmyk_converter_tb;
    import rhcc_pkg::*;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] r, g, b, c, m, y, k;
        logic [8:0] h;
        logic [7:0] s, v;
    } color_in_t;

    typedef struct packed {
        logic [7:0] r, g, b, c, m, y, k;
        logic [8:0] h;
        logic [7:0] s, v;
    } color_out_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    rhcc_req_if request();
    rhcc_rsp_if result();

    rgb_hsv_cmyk_converter DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .request(request.sink),
        .result (result.source)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    color_out_t expected_colors[$];
    int         mismatches = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         hold_off = 0;
    int         quiet_cycles = 0;
    localparam int QUIET_LIMIT = 5000;

    function automatic int unsigned round_div(int unsigned num, int unsigned den);
        return (2 * num + den) / (2 * den);
    endfunction

    // Fill RGB-derived fields; CMYK and HSV parts only where asked
    function automatic void derive_from_rgb(int unsigned r, int unsigned g, int unsigned b,
                                            bit want_cmyk, bit want_hsv,
                                            ref color_out_t o);
        int unsigned hi, lo, d, h;
        hi = r; lo = r;
        if (g > hi) hi = g;
        if (b > hi) hi = b;
        if (g < lo) lo = g;
        if (b < lo) lo = b;
        d = hi - lo;
        o.r = 8'(r); o.g = 8'(g); o.b = 8'(b);
        if (want_cmyk)
        begin
            o.k = 8'(255 - hi);
            if (hi == 0)
            begin
                o.c = '0; o.m = '0; o.y = '0;
            end
            else
            begin
                o.c = 8'(round_div(255 * (hi - r), hi));
                o.m = 8'(round_div(255 * (hi - g), hi));
                o.y = 8'(round_div(255 * (hi - b), hi));
            end
        end
        if (want_hsv)
        begin
            if (d == 0)
                h = 0;
            else if (hi == r)
            begin
                h = round_div(60 * g + 360 * d - 60 * b, d);
                if (h >= 360) h -= 360;
            end
            else if (hi == g)
                h = round_div(60 * b + 120 * d - 60 * r, d);
            else
                h = round_div(60 * r + 240 * d - 60 * g, d);
            o.h = 9'(h);
            o.s = (hi == 0) ? 8'd0 : 8'(round_div(255 * d, hi));
            o.v = 8'(hi);
        end
    endfunction

    function automatic color_out_t convert_color(color_in_t x);
        color_out_t  o;
        int unsigned h, sec, rm, t, cn, xn, mn, r1, g1, b1;
        o = '{default: '0};
        case (x.cmd)
            CMD_RGB: derive_from_rgb(x.r, x.g, x.b, 1'b1, 1'b1, o);
            CMD_CMYK:
            begin
                derive_from_rgb(round_div((255 - x.c) * (255 - x.k), 255),
                                round_div((255 - x.m) * (255 - x.k), 255),
                                round_div((255 - x.y) * (255 - x.k), 255), 1'b0, 1'b1, o);
                o.c = x.c; o.m = x.m; o.y = x.y; o.k = x.k;
            end
            CMD_HSV:
            begin
                h = x.h;
                if (h >= 360) h -= 360;
                sec = h / 60;
                rm = h % 60;
                t = sec[0] ? 60 - rm : rm;
                cn = x.v * x.s * 60;
                xn = x.v * x.s * t;
                mn = (255 * x.v - x.v * x.s) * 60;
                case (sec)
                    0: begin r1 = cn; g1 = xn; b1 = 0;  end
                    1: begin r1 = xn; g1 = cn; b1 = 0;  end
                    2: begin r1 = 0;  g1 = cn; b1 = xn; end
                    3: begin r1 = 0;  g1 = xn; b1 = cn; end
                    4: begin r1 = xn; g1 = 0;  b1 = cn; end
                    default: begin r1 = cn; g1 = 0; b1 = xn; end
                endcase
                derive_from_rgb(round_div(r1 + mn, 15300), round_div(g1 + mn, 15300),
                                round_div(b1 + mn, 15300), 1'b1, 1'b0, o);
                o.h = 9'(h); o.s = x.s; o.v = x.v;
            end
            default: ;
        endcase
        return o;
    endfunction

    initial
    begin
        request.valid = 1'b0;
        request.command = '0;
        request.red = '0; request.green = '0; request.blue = '0;
        request.cyan = '0; request.magenta = '0; request.yellow = '0;
        request.key_black = '0; request.hue = '0;
        request.saturation = '0; request.brightness = '0;
        result.ready = 1'b0;
    end

    // Hold valid between back-to-back transactions; drop it only while idling
    task automatic send_color(color_in_t x);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            request.valid <= 1'b0;
            @(posedge clk);
        end
        request.valid <= 1'b1;
        request.command <= x.cmd;
        request.red <= x.r; request.green <= x.g; request.blue <= x.b;
        request.cyan <= x.c; request.magenta <= x.m; request.yellow <= x.y;
        request.key_black <= x.k; request.hue <= x.h;
        request.saturation <= x.s; request.brightness <= x.v;
        @(posedge clk);
        while (!request.ready) @(posedge clk);
        expected_colors.push_back(convert_color(x));
    endtask

    function automatic color_in_t random_color();
        color_in_t x;
        int        pick;
        pick = $urandom_range(99);
        x.cmd = pick < 33 ? CMD_RGB : pick < 63 ? CMD_CMYK : pick < 96 ? CMD_HSV : CMD_NONE;
        x.r = 8'($urandom); x.g = 8'($urandom); x.b = 8'($urandom);
        x.c = 8'($urandom); x.m = 8'($urandom); x.y = 8'($urandom); x.k = 8'($urandom);
        x.h = 9'($urandom);
        x.s = 8'($urandom); x.v = 8'($urandom);
        // Bias toward ties and extremes now and then
        if ($urandom_range(7) == 0) x.g = x.r;
        if ($urandom_range(7) == 0) x.b = x.g;
        if ($urandom_range(9) == 0) x.v = 8'd255;
        if ($urandom_range(9) == 0) x.s = 8'd0;
        return x;
    endfunction

    function automatic color_in_t make_color(cmd_t cmd, int a, int b, int c, int d);
        color_in_t x;
        x = '{cmd: cmd, default: '0};
        case (cmd)
            CMD_RGB:  begin x.r = 8'(a); x.g = 8'(b); x.b = 8'(c); end
            CMD_CMYK: begin x.c = 8'(a); x.m = 8'(b); x.y = 8'(c); x.k = 8'(d); end
            default:  begin x.h = 9'(a); x.s = 8'(b); x.v = 8'(c); end
        endcase
        return x;
    endfunction

    task automatic test_directed();
        color_in_t x;
        send_color(make_color(CMD_RGB, 0, 0, 0, 0));          // pure black
        send_color(make_color(CMD_RGB, 255, 255, 255, 0));    // white, grey hue
        send_color(make_color(CMD_RGB, 128, 128, 128, 0));
        send_color(make_color(CMD_RGB, 255, 0, 0, 0));
        send_color(make_color(CMD_RGB, 255, 0, 1, 0));        // red with hue wrap
        send_color(make_color(CMD_RGB, 200, 200, 10, 0));     // red wins tie
        send_color(make_color(CMD_RGB, 3, 200, 200, 0));      // green wins tie
        send_color(make_color(CMD_RGB, 1, 0, 255, 0));
        send_color(make_color(CMD_CMYK, 0, 0, 0, 0));
        send_color(make_color(CMD_CMYK, 255, 255, 255, 255));
        send_color(make_color(CMD_CMYK, 0, 0, 0, 255));
        send_color(make_color(CMD_CMYK, 255, 0, 128, 17));
        send_color(make_color(CMD_HSV, 0, 255, 255, 0));
        send_color(make_color(CMD_HSV, 359, 255, 255, 0));
        send_color(make_color(CMD_HSV, 360, 200, 100, 0));    // hue reduced
        send_color(make_color(CMD_HSV, 511, 255, 255, 0));
        send_color(make_color(CMD_HSV, 60, 0, 255, 0));
        send_color(make_color(CMD_HSV, 179, 128, 0, 0));
        send_color(make_color(CMD_HSV, 300, 255, 128, 0));
        x = '{cmd: CMD_NONE, r: 8'hff, g: 8'hff, b: 8'hff, c: 8'hff, m: 8'hff,
              y: 8'hff, k: 8'hff, h: 9'h1ff, s: 8'hff, v: 8'hff};
        send_color(x);                                         // unused command
    endtask

    task automatic test_random(int count);
        repeat (count) send_color(random_color());
    endtask

    task automatic test_backpressure();
        hold_off = 60;
        repeat (40) send_color(random_color());
    endtask

    always @(posedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            result.ready <= 1'b0;
        end
        else
            result.ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        color_out_t e, a;
        if (rst_n && result.valid && result.ready)
        begin
            a = '{result.res_red, result.res_green, result.res_blue, result.res_cyan,
                  result.res_magenta, result.res_yellow, result.res_black,
                  result.res_hue, result.res_saturation, result.res_brightness};
            if (expected_colors.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transaction: %p", a);
            end
            else
            begin
                e = expected_colors.pop_front();
                if (a !== e)
                begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch: expected %p got %p", e, a);
                end
            end
        end
    end

    // Watchdog on cycles without any accepted transaction
    always @(posedge clk)
    begin
        if ((request.valid && request.ready) || (result.valid && result.ready))
            quiet_cycles <= 0;
        else if (rst_n)
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        send_idle_pct = 18; recv_idle_pct = 68;
        test_random(180);
        test_backpressure();
        send_idle_pct = 68; recv_idle_pct = 18;
        test_random(150);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random(160);
        request.valid <= 1'b0;
        while (expected_colors.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_colors.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
